// ----- rtl/cpbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cpbs_pkg
// Shared types, constants and the microcode program of the blend-stops unit.
// ----------------------------------------------------------------------------
package cpbs_pkg;

  // luminance weights
  localparam logic [9:0] LUMA_W_RED   = 10'd299;
  localparam logic [9:0] LUMA_W_GREEN = 10'd587;
  localparam logic [9:0] LUMA_W_BLUE  = 10'd114;

  localparam int LUMA_W  = 18;
  localparam int CHAN_W  = 8;
  localparam int TOTAL_W = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;
  localparam int PC_W = 4;

  localparam logic [1:0] CH_LAST   = 2'd2;
  localparam logic [2:0] ITER_LAST = 3'd7;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_LUMA,
    UOP_UPDATE,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_DIV_STORE,
    UOP_BLEND,
    UOP_CLEAR,
    UOP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_CLEAR,
    COND_FULL,
    COND_LT2,
    COND_ITER_MORE,
    COND_CH_MORE,
    COND_OUT_FULL
  } cond_e;

  typedef struct packed {
    uop_e             uop;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic is_clear;
    logic full;
    logic lt2;
    logic iter_more;
    logic ch_more;
    logic out_full;
  } status_t;

  // program step addresses
  localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] STEP_DECODE   = 4'd1;
  localparam logic [PC_W-1:0] STEP_LUMA     = 4'd2;
  localparam logic [PC_W-1:0] STEP_UPDATE   = 4'd3;
  localparam logic [PC_W-1:0] STEP_CHECK    = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_STEP = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIV_DONE = 4'd7;
  localparam logic [PC_W-1:0] STEP_BLEND    = 4'd8;
  localparam logic [PC_W-1:0] STEP_CLEAR    = 4'd9;
  localparam logic [PC_W-1:0] STEP_EMIT     = 4'd10;
  localparam logic [PC_W-1:0] STEP_RETURN   = 4'd11;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_WAIT:     w = '{UOP_ACCEPT,    COND_NO_INPUT,  STEP_WAIT};
      STEP_DECODE:   w = '{UOP_NOP,       COND_IS_CLEAR,  STEP_CLEAR};
      STEP_LUMA:     w = '{UOP_LUMA,      COND_FULL,      STEP_EMIT};
      STEP_UPDATE:   w = '{UOP_UPDATE,    COND_NEVER,     STEP_WAIT};
      STEP_CHECK:    w = '{UOP_NOP,       COND_LT2,       STEP_EMIT};
      STEP_DIV_INIT: w = '{UOP_DIV_INIT,  COND_NEVER,     STEP_WAIT};
      STEP_DIV_STEP: w = '{UOP_DIV_STEP,  COND_ITER_MORE, STEP_DIV_STEP};
      STEP_DIV_DONE: w = '{UOP_DIV_STORE, COND_CH_MORE,   STEP_DIV_INIT};
      STEP_BLEND:    w = '{UOP_BLEND,     COND_ALWAYS,    STEP_EMIT};
      STEP_CLEAR:    w = '{UOP_CLEAR,     COND_NEVER,     STEP_WAIT};
      STEP_EMIT:     w = '{UOP_EMIT,      COND_OUT_FULL,  STEP_EMIT};
      STEP_RETURN:   w = '{UOP_NOP,       COND_ALWAYS,    STEP_WAIT};
      default:       w = '{UOP_NOP,       COND_ALWAYS,    STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/cpbs_seq.sv -----
// ----------------------------------------------------------------------------
// cpbs_seq
// Step counter and control store; picks the next step from the jump field.
// ----------------------------------------------------------------------------
module cpbs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpbs_pkg::status_t  status_i,
  output cpbs_pkg::uop_e     uop_o
);

  logic [cpbs_pkg::PC_W-1:0] pc_q, pc_d;
  cpbs_pkg::ucode_t          word;
  logic                      take;

  always_comb begin
    word = cpbs_pkg::ucode_rom(pc_q);
    unique case (word.cond)
      cpbs_pkg::COND_NEVER:     take = 1'b0;
      cpbs_pkg::COND_ALWAYS:    take = 1'b1;
      cpbs_pkg::COND_NO_INPUT:  take = !status_i.in_valid;
      cpbs_pkg::COND_IS_CLEAR:  take = status_i.is_clear;
      cpbs_pkg::COND_FULL:      take = status_i.full;
      cpbs_pkg::COND_LT2:       take = status_i.lt2;
      cpbs_pkg::COND_ITER_MORE: take = status_i.iter_more;
      cpbs_pkg::COND_CH_MORE:   take = status_i.ch_more;
      cpbs_pkg::COND_OUT_FULL:  take = status_i.out_full;
      default:                  take = 1'b0;
    endcase
    pc_d  = take ? word.target : pc_q + 1'b1;
    uop_o = word.uop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cpbs_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- rtl/cpbs_datapath.sv -----
// ----------------------------------------------------------------------------
// cpbs_datapath
// Sums, count, extremes, shared restoring divider, blend adders, output stage.
// ----------------------------------------------------------------------------
module cpbs_datapath #(
  parameter int MAX_PICKS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpbs_pkg::uop_e                      uop_i,
  input  logic                                in_valid_i,
  input  logic [cpbs_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                in_user_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [cpbs_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_user_o,
  output cpbs_pkg::status_t                   status_o
);

  localparam int CW = $clog2(MAX_PICKS + 1);
  localparam int DW = CW + cpbs_pkg::CHAN_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PICKS);
  localparam logic [CW-1:0] TWO_CNT = CW'(2);

  localparam int CH = cpbs_pkg::CHAN_W;
  localparam int LW = cpbs_pkg::LUMA_W;

  logic          op_q;
  logic [CH-1:0] pix_q    [3];
  logic [LW-1:0] luma_q;
  logic [DW-1:0] sum_q    [3];
  logic [CW-1:0] count_q;
  logic [CH-1:0] dark_q   [3];
  logic [CH-1:0] bright_q [3];
  logic [LW-1:0] dark_luma_q, bright_luma_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [CH-1:0] quo_q;
  logic [2:0]    iter_q;
  logic [1:0]    ch_q;
  logic [CH-1:0] low_q    [3];
  logic [CH-1:0] mean_q   [3];
  logic [CH-1:0] high_q   [3];
  logic          stops_ok_q;
  logic          out_valid_q;
  logic [cpbs_pkg::OUT_DATA_W-1:0] out_data_q;
  logic          out_user_q;

  logic [LW-1:0] luma_d;
  logic [DW-1:0] sum_sel;
  logic          rem_ge;
  logic [CH-1:0] low_d  [3];
  logic [CH-1:0] high_d [3];
  logic [CH-1:0] gate   [9];

  always_comb begin
    luma_d = LW'(pix_q[0]) * LW'(cpbs_pkg::LUMA_W_RED)
           + LW'(pix_q[1]) * LW'(cpbs_pkg::LUMA_W_GREEN)
           + LW'(pix_q[2]) * LW'(cpbs_pkg::LUMA_W_BLUE);
    case (ch_q)
      2'd0:    sum_sel = sum_q[0];
      2'd1:    sum_sel = sum_q[1];
      default: sum_sel = sum_q[2];
    endcase
    rem_ge = (rem_q >= dvs_q);
    for (int i = 0; i < 3; i++) begin
      low_d[i]  = CH'(({1'b0, dark_q[i]} + {1'b0, mean_q[i]} + 9'd1) >> 1);
      high_d[i] = CH'(({1'b0, mean_q[i]} + {1'b0, bright_q[i]} + 9'd1) >> 1);
      gate[i]     = stops_ok_q ? low_q[i]  : '0;
      gate[3 + i] = stops_ok_q ? mean_q[i] : '0;
      gate[6 + i] = stops_ok_q ? high_q[i] : '0;
    end
  end

  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.is_clear  = op_q;
    status_o.full      = (count_q >= MAX_CNT);
    status_o.lt2       = (count_q < TWO_CNT);
    status_o.iter_more = (iter_q != '0);
    status_o.ch_more   = (ch_q != cpbs_pkg::CH_LAST);
    status_o.out_full  = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q          <= 1'b0;
      luma_q        <= '0;
      count_q       <= '0;
      dark_luma_q   <= '0;
      bright_luma_q <= '0;
      rem_q         <= '0;
      dvs_q         <= '0;
      quo_q         <= '0;
      stops_ok_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      iter_q        <= '0;
      ch_q          <= '0;
      for (int i = 0; i < 3; i++) begin
        pix_q[i]    <= '0;
        sum_q[i]    <= '0;
        dark_q[i]   <= '0;
        bright_q[i] <= '0;
        low_q[i]    <= '0;
        mean_q[i]   <= '0;
        high_q[i]   <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (uop_i)
        cpbs_pkg::UOP_ACCEPT: begin
          if (in_valid_i) begin
            op_q     <= in_user_i;
            pix_q[0] <= in_data_i[7:0];
            pix_q[1] <= in_data_i[15:8];
            pix_q[2] <= in_data_i[23:16];
          end
        end
        cpbs_pkg::UOP_LUMA: begin
          luma_q <= luma_d;
        end
        cpbs_pkg::UOP_UPDATE: begin
          // first colour seeds both extremes; dark keeps the first minimum
          if (count_q == '0 || luma_q < dark_luma_q) begin
            dark_luma_q <= luma_q;
            for (int i = 0; i < 3; i++) dark_q[i] <= pix_q[i];
          end
          if (count_q == '0 || luma_q >= bright_luma_q) begin
            bright_luma_q <= luma_q;
            for (int i = 0; i < 3; i++) bright_q[i] <= pix_q[i];
          end
          for (int i = 0; i < 3; i++) sum_q[i] <= sum_q[i] + DW'(pix_q[i]);
          count_q <= count_q + 1'b1;
          ch_q    <= '0;
        end
        cpbs_pkg::UOP_DIV_INIT: begin
          // round to nearest by adding half the divisor
          rem_q  <= sum_sel + DW'(count_q >> 1);
          dvs_q  <= DW'(count_q) << 7;
          iter_q <= cpbs_pkg::ITER_LAST;
        end
        cpbs_pkg::UOP_DIV_STEP: begin
          if (rem_ge) begin
            rem_q <= rem_q - dvs_q;
          end
          quo_q  <= {quo_q[CH-2:0], rem_ge};
          dvs_q  <= dvs_q >> 1;
          iter_q <= iter_q - 1'b1;
        end
        cpbs_pkg::UOP_DIV_STORE: begin
          mean_q[ch_q] <= quo_q;
          ch_q         <= ch_q + 1'b1;
        end
        cpbs_pkg::UOP_BLEND: begin
          for (int i = 0; i < 3; i++) begin
            low_q[i]  <= low_d[i];
            high_q[i] <= high_d[i];
          end
          stops_ok_q <= 1'b1;
        end
        cpbs_pkg::UOP_CLEAR: begin
          count_q       <= '0;
          dark_luma_q   <= '0;
          bright_luma_q <= '0;
          stops_ok_q    <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            sum_q[i]    <= '0;
            dark_q[i]   <= '0;
            bright_q[i] <= '0;
          end
        end
        cpbs_pkg::UOP_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload, loaded when the output stage is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_user_q <= 1'b0;
      out_data_q <= '0;
    end else if (uop_i == cpbs_pkg::UOP_EMIT && !out_valid_q) begin
      out_user_q <= stops_ok_q;
      out_data_q <= {7'b0, gate[8], gate[7], gate[6], gate[5], gate[4], gate[3],
                     gate[2], gate[1], gate[0], cpbs_pkg::TOTAL_W'(count_q)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  a_stops_need_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stops_ok_q |-> (count_q >= TWO_CNT))
    else $error("stops marked valid with fewer than two colors");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("held count above capacity");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == cpbs_pkg::UOP_DIV_STORE) |-> (rem_q < DW'(count_q)))
    else $error("divider remainder not below count");

endmodule

// ----- rtl/color_pick_blend_stops_unit.sv -----
// Sequence: an accepted add that leaves two or more colors held runs the shared
//   8-step restoring divider once per channel, then blends and emits; the
//   first add after a clear, a clear, or an add to a full selection emits
//   without dividing. Flow: one item in flight; the next item is accepted
//   only after the previous result is loaded into the output stage.
// Reset: all sums, count, extremes and stops return to zero; output empty.
// ----------------------------------------------------------------------------
// color_pick_blend_stops_unit
// Running color pick statistics: mean plus dark and bright blend stops.
// ----------------------------------------------------------------------------
module color_pick_blend_stops_unit #(
  parameter int MAX_PICKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser_i,  // op: 0 add, 1 clear
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pick_total[8:0], low_blend r/g/b, mean r/g/b, high_blend r/g/b, zero pad
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o   // stops_live: two or more colors held
);

  cpbs_pkg::uop_e    uop;
  cpbs_pkg::status_t status;

  cpbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uop_o    (uop)
  );

  cpbs_datapath #(
    .MAX_PICKS (MAX_PICKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (uop),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .status_o    (status)
  );

  assign s_axis_tready_o = (uop == cpbs_pkg::UOP_ACCEPT);

endmodule
